[rtl/rcpt_pkg.sv]
package rcpt_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int NUM_REGS      = 8;
   localparam int NUM_CORNERS   = 4;
   localparam int QUO_BITS      = 32;
   localparam int REQ_BITS      = 160;
   localparam int RSP_BITS      = 72;

   localparam logic [31:0] QUO_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] QUO_MIN = 32'h8000_0000;
   localparam logic [1:0]  CORNER_LAST = 2'd3;

   // register indexes of the configuration port
   typedef enum logic [2:0] {
      REG_SCALE_X,
      REG_SKEW_X,
      REG_TRANS_X,
      REG_SKEW_Y,
      REG_SCALE_Y,
      REG_TRANS_Y,
      REG_PERSP_X,
      REG_PERSP_Y
   } reg_idx_type;

   // matrix terms held in the configuration registers
   typedef struct packed {
      logic signed [31:0] sx;
      logic signed [31:0] kx;
      logic signed [31:0] tx;
      logic signed [31:0] ky;
      logic signed [31:0] sy;
      logic signed [31:0] ty;
      logic signed [31:0] px;
      logic signed [31:0] py;
   } matrix_type;

   // stage enables handed to each corner lane
   typedef struct packed {
      logic mul_en;
      logic sum_en;
   } lane_en_type;

   // per-quotient flags carried down the divider stages
   typedef struct packed {
      logic neg;
      logic zero;
      logic ovf;
      logic npos;
      logic nneg;
   } div_flag_type;

endpackage

[rtl/rcpt_lane.sv]
module rcpt_lane #(
   parameter int FRAC_BITS = rcpt_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  rcpt_pkg::lane_en_type         en,
   input  rcpt_pkg::matrix_type          mat,
   input  logic signed [31:0]            x,
   input  logic signed [31:0]            y,
   input  logic signed [31:0]            bias,
   output logic signed [65-FRAC_BITS:0]  sum_x_ff,
   output logic signed [65-FRAC_BITS:0]  sum_y_ff,
   output logic signed [65-FRAC_BITS:0]  sum_w_ff
);
   import rcpt_pkg::*;

   localparam int SW = 66 - FRAC_BITS;
   localparam int PW = 64 - FRAC_BITS;

   logic signed [63:0] p_sx_ff, p_kx_ff, p_ky_ff, p_sy_ff, p_px_ff, p_py_ff;
   logic signed [31:0] bias_ff;
   logic signed [PW-1:0] t_sx, t_kx, t_ky, t_sy, t_px, t_py;

   // six exact products of the corner
   always_ff @(posedge clock) begin
      if (en.mul_en) begin
         p_sx_ff <= mat.sx * x;
         p_kx_ff <= mat.kx * y;
         p_ky_ff <= mat.ky * x;
         p_sy_ff <= mat.sy * y;
         p_px_ff <= mat.px * x;
         p_py_ff <= mat.py * y;
         bias_ff <= bias;
      end
   end

   // drop fraction bits, rounding toward minus infinity
   assign t_sx = p_sx_ff[63:FRAC_BITS];
   assign t_kx = p_kx_ff[63:FRAC_BITS];
   assign t_ky = p_ky_ff[63:FRAC_BITS];
   assign t_sy = p_sy_ff[63:FRAC_BITS];
   assign t_px = p_px_ff[63:FRAC_BITS];
   assign t_py = p_py_ff[63:FRAC_BITS];

   // exact row sums
   always_ff @(posedge clock) begin
      if (en.sum_en) begin
         sum_x_ff <= SW'(t_sx) + SW'(t_kx) + SW'(mat.tx);
         sum_y_ff <= SW'(t_ky) + SW'(t_sy) + SW'(mat.ty);
         sum_w_ff <= SW'(t_px) + SW'(t_py) + SW'(bias_ff);
      end
   end

endmodule

[rtl/rcpt_div.sv]
module rcpt_div #(
   parameter int FRAC_BITS = rcpt_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [65-FRAC_BITS:0]  num,
   input  logic signed [65-FRAC_BITS:0]  den,
   output logic [31:0]                   quo,
   output logic                          sat
);
   import rcpt_pkg::*;

   localparam int SW = 66 - FRAC_BITS;
   localparam int IB = 32 - FRAC_BITS;

   logic [SW:0]      rem_ff  [0:QUO_BITS];
   logic [SW-1:0]    den_ff  [0:QUO_BITS];
   logic [31:0]      lo_ff   [0:QUO_BITS];
   div_flag_type     flg_ff  [0:QUO_BITS];

   logic [SW-1:0]    abs_n, abs_d;
   div_flag_type     flg_in;
   logic [31:0]      q;
   div_flag_type     fl;

   // magnitudes, overflow and zero checks
   always_comb begin
      abs_n = num[SW-1] ? SW'(-num) : SW'(num);
      abs_d = den[SW-1] ? SW'(-den) : SW'(den);
      flg_in.neg  = num[SW-1] ^ den[SW-1];
      flg_in.zero = (den == '0);
      flg_in.ovf  = {{IB{1'b0}}, abs_n} >= {abs_d, {IB{1'b0}}};
      flg_in.npos = !num[SW-1] && (num != '0);
      flg_in.nneg = num[SW-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= (SW+1)'(abs_n >> IB);
         den_ff[0] <= abs_d;
         lo_ff[0]  <= {abs_n[IB-1:0], {FRAC_BITS{1'b0}}};
         flg_ff[0] <= flg_in;
      end
   end

   // one quotient bit per stage
   for (genvar i = 0; i < QUO_BITS; i++) begin : g_step
      logic [SW:0] rt;
      logic        ge;
      assign rt = {rem_ff[i][SW-1:0], lo_ff[i][31]};
      assign ge = rt >= {1'b0, den_ff[i]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1] <= ge ? rt - {1'b0, den_ff[i]} : rt;
            den_ff[i+1] <= den_ff[i];
            lo_ff[i+1]  <= {lo_ff[i][30:0], ge};
            flg_ff[i+1] <= flg_ff[i];
         end
      end
   end

   // sign and saturation
   always_comb begin
      q  = lo_ff[QUO_BITS];
      fl = flg_ff[QUO_BITS];
      sat = 1'b0;
      quo = q;
      priority if (fl.zero) begin
         sat = 1'b1;
         quo = fl.npos ? QUO_MAX : (fl.nneg ? QUO_MIN : '0);
      end else if (fl.ovf) begin
         sat = 1'b1;
         quo = fl.neg ? QUO_MIN : QUO_MAX;
      end else if (fl.neg) begin
         if (q > QUO_MIN) begin
            sat = 1'b1;
            quo = QUO_MIN;
         end else begin
            quo = 32'(-q);
         end
      end else begin
         if (q > QUO_MAX) begin
            sat = 1'b1;
            quo = QUO_MAX;
         end
      end
   end

endmodule

[rtl/rect_corner_projective_transform_top.sv]
// channel   | dir | handshake             | payload
// req       | in  | req_tvalid/req_tready | tdata: left, top, right, bottom, bias
// rsp       | out | rsp_tvalid/rsp_tready | tdata: corner, x, y; tuser: sat; tlast
// csr       | in  | csr_we                | csr_idx, csr_wdata
//
// one corner item per cycle while the output is not stalled, paced by the shared
// x/y divider pair; the input and product stages take new rectangles while the
// sum stage still sends corners; each corner passes input capture, the product
// and sum stages, 33 divider stages and the output register
// synchronous reset clears all valid bits and loads the identity matrix
// a stalled output freezes the divider line; the input side fills until full
module rect_corner_projective_transform_top #(
   parameter int FRAC_BITS = rcpt_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // rect_left, rect_top, rect_right, rect_bottom, persp_bias
   input  logic [rcpt_pkg::REQ_BITS-1:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // corner_index, out_x, out_y, zero fill
   output logic [rcpt_pkg::RSP_BITS-1:0]  rsp_tdata,
   // saturated
   output logic                           rsp_tuser,
   output logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [2:0]                     csr_idx,
   input  logic [31:0]                    csr_wdata
);
   import rcpt_pkg::*;

   localparam int SW    = 66 - FRAC_BITS;
   localparam int DEPTH = QUO_BITS + 1;

   matrix_type          mat_ff;
   logic                a_v_ff, mul_v_ff, sum_v_ff;
   logic signed [31:0]  l_ff, t_ff, r_ff, b_ff, p2_ff;
   logic [1:0]          cnt_ff;
   logic                tag_v_ff   [0:DEPTH-1];
   logic [1:0]          tag_idx_ff [0:DEPTH-1];
   logic                rsp_v_ff, rsp_sat_ff;
   logic [1:0]          rsp_idx_ff;
   logic [31:0]         rsp_x_ff, rsp_y_ff;

   logic                adv, sum_take;
   lane_en_type         len;
   logic                a_en;
   logic signed [SW-1:0] lx [NUM_CORNERS];
   logic signed [SW-1:0] ly [NUM_CORNERS];
   logic signed [SW-1:0] lw [NUM_CORNERS];
   logic [31:0]         qx, qy;
   logic                sx, sy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= '{sx: 32'(1) << FRAC_BITS, sy: 32'(1) << FRAC_BITS, default: '0};
      end else if (csr_we) begin
         unique case (reg_idx_type'(csr_idx))
            REG_SCALE_X: mat_ff.sx <= csr_wdata;
            REG_SKEW_X:  mat_ff.kx <= csr_wdata;
            REG_TRANS_X: mat_ff.tx <= csr_wdata;
            REG_SKEW_Y:  mat_ff.ky <= csr_wdata;
            REG_SCALE_Y: mat_ff.sy <= csr_wdata;
            REG_TRANS_Y: mat_ff.ty <= csr_wdata;
            REG_PERSP_X: mat_ff.px <= csr_wdata;
            REG_PERSP_Y: mat_ff.py <= csr_wdata;
         endcase
      end
   end

   // stage enables, bubbles collapse toward the merge stage
   assign adv        = !rsp_v_ff || rsp_tready;
   assign sum_take   = adv && (cnt_ff == CORNER_LAST);
   assign len.sum_en = !sum_v_ff || sum_take;
   assign len.mul_en = !mul_v_ff || len.sum_en;
   assign a_en       = !a_v_ff || len.mul_en;
   assign req_tready = a_en;

   // input capture
   always_ff @(posedge clock) begin
      if (a_en) begin
         l_ff  <= req_tdata[31:0];
         t_ff  <= req_tdata[63:32];
         r_ff  <= req_tdata[95:64];
         b_ff  <= req_tdata[127:96];
         p2_ff <= req_tdata[159:128];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff   <= 1'b0;
         mul_v_ff <= 1'b0;
         sum_v_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         if (a_en)              a_v_ff   <= req_tvalid;
         if (len.mul_en)        mul_v_ff <= a_v_ff;
         if (len.sum_en)        sum_v_ff <= mul_v_ff;
         if (adv && sum_v_ff)   cnt_ff   <= cnt_ff + 2'd1;
      end
   end

   // one lane per corner
   for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_lane
      rcpt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock    (clock),
         .en       (len),
         .mat      (mat_ff),
         .x        ((k < 2) ? l_ff : r_ff),
         .y        ((k % 2 == 1) ? b_ff : t_ff),
         .bias     (p2_ff),
         .sum_x_ff (lx[k]),
         .sum_y_ff (ly[k]),
         .sum_w_ff (lw[k])
      );
   end

   // merge: corners leave the lanes one per cycle into the dividers unless stalled
   rcpt_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock (clock),
      .en    (adv),
      .num   (lx[cnt_ff]),
      .den   (lw[cnt_ff]),
      .quo   (qx),
      .sat   (sx)
   );

   rcpt_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock (clock),
      .en    (adv),
      .num   (ly[cnt_ff]),
      .den   (lw[cnt_ff]),
      .quo   (qy),
      .sat   (sy)
   );

   // corner tags travel beside the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) tag_v_ff[i] <= 1'b0;
      end else if (adv) begin
         tag_v_ff[0] <= sum_v_ff;
         for (int i = 1; i < DEPTH; i++) tag_v_ff[i] <= tag_v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_idx_ff[0] <= cnt_ff;
         for (int i = 1; i < DEPTH; i++) tag_idx_ff[i] <= tag_idx_ff[i-1];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff <= tag_v_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_idx_ff <= tag_idx_ff[DEPTH-1];
         rsp_x_ff   <= qx;
         rsp_y_ff   <= qy;
         rsp_sat_ff <= sx | sy;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {6'b0, rsp_y_ff, rsp_x_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tlast  = (rsp_idx_ff == CORNER_LAST);

endmodule

[rtl/rcpt_check.sv]
module rcpt_check (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rcpt_pkg::RSP_BITS-1:0]  rsp_tdata,
   input logic                           rsp_tuser,
   input logic                           rsp_tlast
);
   import rcpt_pkg::*;

   // nothing leaves right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled item holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // last marks the fourth corner only
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[1:0] == CORNER_LAST)))
      else $error("last flag disagrees with corner index");

   // padding bits stay clear
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_BITS-1:66] == '0))
      else $error("padding bits set");

endmodule

bind rect_corner_projective_transform_top rcpt_check u_check (.*);

[dv/rcpt_checker.sv]
module rcpt_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [rcpt_pkg::REQ_BITS-1:0]  req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [rcpt_pkg::RSP_BITS-1:0]  rsp_tdata,
   input  logic                           rsp_tuser,
   input  logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [2:0]                     csr_idx,
   input  logic [31:0]                    csr_wdata,
   output int                             errors,
   output int                             outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import rcpt_pkg::*;

   localparam int FB = FRAC_BITS_DEF;

   typedef struct packed {
      logic [1:0]  corner;
      logic [31:0] x;
      logic [31:0] y;
      logic        sat;
      logic        last;
   } corner_item_type;

   matrix_type      mtx;
   corner_item_type corners_due[$];

   assign outstanding = corners_due.size();

   // fixed-point product, floored to the fraction width
   function automatic logic signed [63:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return p >>> FB;
   endfunction

   // fixed-point quotient toward zero; bit 32 flags saturation
   function automatic logic [32:0] qdiv(logic signed [63:0] n, logic signed [63:0] w);
      logic         neg;
      logic [63:0]  an, ad;
      logic [127:0] q;
      if (w == 0) begin
         if (n > 0) return {1'b1, QUO_MAX};
         if (n < 0) return {1'b1, QUO_MIN};
         return {1'b1, 32'd0};
      end
      neg = (n < 0) != (w < 0);
      an  = (n < 0) ? -n : n;
      ad  = (w < 0) ? -w : w;
      q   = ({64'd0, an} << FB) / {64'd0, ad};
      if (neg) begin
         if (q > 128'h8000_0000) return {1'b1, QUO_MIN};
         return {1'b0, 32'(-q[31:0])};
      end
      if (q > 128'h7FFF_FFFF) return {1'b1, QUO_MAX};
      return {1'b0, q[31:0]};
   endfunction

   // map one rectangle corner through the current matrix
   function automatic corner_item_type project_corner(int k, logic signed [31:0] px_in,
                                                      logic signed [31:0] py_in,
                                                      logic signed [31:0] bias);
      logic signed [63:0] nx, ny, w;
      logic [32:0]        qx, qy;
      corner_item_type    c;
      nx = qmul(mtx.sx, px_in) + qmul(mtx.kx, py_in) + 64'(mtx.tx);
      ny = qmul(mtx.ky, px_in) + qmul(mtx.sy, py_in) + 64'(mtx.ty);
      w  = qmul(mtx.px, px_in) + qmul(mtx.py, py_in) + 64'(bias);
      qx = qdiv(nx, w);
      qy = qdiv(ny, w);
      c.corner = 2'(k);
      c.x      = qx[31:0];
      c.y      = qy[31:0];
      c.sat    = qx[32] | qy[32];
      c.last   = (2'(k) == CORNER_LAST);
      return c;
   endfunction

   // register shadow, rectangle expansion and corner compare
   always @(posedge clock) begin
      logic signed [31:0] l, t, r, b, bias;
      corner_item_type    got, want;
      if (reset) begin
         mtx <= '{sx: 32'sd65536, sy: 32'sd65536, default: '0};
      end else begin
         if (csr_we) begin
            case (reg_idx_type'(csr_idx))
               REG_SCALE_X: mtx.sx <= csr_wdata;
               REG_SKEW_X:  mtx.kx <= csr_wdata;
               REG_TRANS_X: mtx.tx <= csr_wdata;
               REG_SKEW_Y:  mtx.ky <= csr_wdata;
               REG_SCALE_Y: mtx.sy <= csr_wdata;
               REG_TRANS_Y: mtx.ty <= csr_wdata;
               REG_PERSP_X: mtx.px <= csr_wdata;
               REG_PERSP_Y: mtx.py <= csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            {bias, b, r, t, l} = req_tdata;
            for (int k = 0; k < NUM_CORNERS; k++)
               corners_due.push_back(project_corner(k, (k < 2) ? l : r,
                                                    k[0] ? b : t, bias));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.corner = rsp_tdata[1:0];
            got.x      = rsp_tdata[33:2];
            got.y      = rsp_tdata[65:34];
            got.sat    = rsp_tuser;
            got.last   = rsp_tlast;
            if (corners_due.size() == 0) begin
               $display("%0t: corner item with nothing pending: %p", $realtime, got);
               errors++;
            end else begin
               want = corners_due.pop_front();
               if (got.corner !== want.corner || got.x !== want.x || got.y !== want.y ||
                   got.sat !== want.sat || got.last !== want.last) begin
                  $display("%0t: corner mismatch expected %p actual %p",
                           $realtime, want, got);
                  errors++;
               end
            end
         end
      end
   end

   initial errors = 0;

endmodule

[dv/tb_rect_corner_projective_transform_top.sv]
module tb_rect_corner_projective_transform_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rcpt_pkg::*;

   localparam int ONE        = 65536;
   localparam int CYCLE_CAP  = 400000;
   localparam int DRAIN_WAIT = 60;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic                rsp_tuser;
   logic                rsp_tlast;
   logic                csr_we;
   logic [2:0]          csr_idx;
   logic [31:0]         csr_wdata;
   int                  errors;
   int                  outstanding;
   int                  cycles;
   int                  stall_left;

   rect_corner_projective_transform_top dut (.*);

   rcpt_checker checker_i (.*);

   always #1 clock = ~clock;

   // quiet windows with no idling on either side
   function automatic bit quiet_window();
      return (cycles / 1500) % 4 == 3;
   endfunction

   // random receiver stalls, mostly short
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_CAP) begin
         $display("[rect_corner_projective_transform_top] ERROR");
         $finish;
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!reset && !quiet_window()) begin
            if ($urandom_range(0, 99) < 15) stall_left <= $urandom_range(1, 3);
            else if ($urandom_range(0, 99) < 3) stall_left <= $urandom_range(10, 40);
         end
      end
   end

   // value with bias toward the interesting corners of the range
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return $urandom;
         3:       return $urandom_range(0, 255) - 128;
         default: return $urandom_range(0, 2 * 500 * ONE) - 500 * ONE;
      endcase
   endfunction

   function automatic logic [31:0] pick_term(bit persp);
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return $urandom;
         3:       return 0;
         default: return persp ? $urandom_range(0, 1024) - 512
                               : $urandom_range(0, 8 * ONE) - 4 * ONE;
      endcase
   endfunction

   function automatic logic [31:0] pick_bias();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return $urandom;
         2:       return $urandom_range(0, 255) - 128;
         default: return ONE;
      endcase
   endfunction

   // offer one rectangle and hold it until taken
   task automatic send_rect(logic [31:0] l, logic [31:0] t, logic [31:0] r,
                            logic [31:0] b, logic [31:0] bias);
      bit taken;
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {bias, b, r, t, l};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      gap = 0;
      if (!quiet_window()) begin
         if ($urandom_range(0, 99) < 25) gap = $urandom_range(1, 3);
         else if ($urandom_range(0, 99) < 4) gap = $urandom_range(10, 50);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait until all corners are back and the pipe is empty
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic load_matrix(logic [31:0] terms[NUM_REGS]);
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_we    <= 1'b1;
         csr_idx   <= 3'(reg_idx_type'(i));
         csr_wdata <= terms[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic random_rects(int count);
      logic [31:0] l, t;
      for (int i = 0; i < count; i++) begin
         l = pick_coord();
         t = pick_coord();
         send_rect(l, t, ($urandom_range(0, 3) == 0) ? l : pick_coord(), pick_coord(),
                   pick_bias());
      end
   endtask

   initial begin
      logic [31:0] terms[NUM_REGS];
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_idx    = '0;
      csr_wdata  = '0;
      cycles     = 0;
      stall_left = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity matrix: extremes, w zero with each numerator sign, overflow
      send_rect(0, 0, 0, 0, ONE);
      send_rect(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, ONE);
      send_rect(ONE, -ONE, -ONE, 0, 0);
      send_rect(3 * ONE, 5 * ONE, -7 * ONE, 2 * ONE, 2 * ONE);
      send_rect(100 * ONE, -100 * ONE, 1, -1, 1);
      send_rect(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, -1);
      send_rect(5 * ONE, 5 * ONE, -5 * ONE, -5 * ONE, -ONE);
      send_rect(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000);
      send_rect(ONE, ONE, 2 * ONE, 2 * ONE, 32'h7FFF_FFFF);
      drain();

      // perspective matrix where w changes sign between the corners of a rectangle
      terms = '{2 * ONE, ONE / 2, 10 * ONE, -ONE / 4, 3 * ONE, -7 * ONE, ONE, 0};
      load_matrix(terms);
      send_rect(-ONE, 0, ONE, 4 * ONE, 0);
      send_rect(2 * ONE, 3 * ONE, -2 * ONE, -3 * ONE, ONE);
      send_rect(10 * ONE, ONE, 32'h7FFF_FFFF, 32'h8000_0000, ONE / 2);
      random_rects(10);
      drain();

      // extreme matrices
      terms = '{default: 32'h7FFF_FFFF};
      load_matrix(terms);
      send_rect(ONE, ONE, -ONE, 32'h7FFF_FFFF, ONE);
      random_rects(15);
      drain();
      terms = '{default: 32'h8000_0000};
      load_matrix(terms);
      send_rect(ONE, -ONE, 32'h8000_0000, 0, 32'h8000_0000);
      random_rects(15);
      drain();

      // random phases: affine, then projective
      for (int ph = 0; ph < 6; ph++) begin
         for (int i = 0; i < NUM_REGS; i++)
            terms[i] = (ph < 2 && i >= 6) ? 32'd0 : pick_term(i >= 6);
         load_matrix(terms);
         random_rects(45);
         drain();
      end

      if (errors == 0)
         $display("[rect_corner_projective_transform_top] OK");
      else
         $display("[rect_corner_projective_transform_top] ERROR");
      $finish;
   end

endmodule
